// ----- rtl/timer_deadline_min_heap_defines.svh -----
// Assertion macros used by the timer heap top level.
`ifndef TIMER_DEADLINE_MIN_HEAP_DEFINES_SVH
`define TIMER_DEADLINE_MIN_HEAP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TDH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Next-cycle implication checked outside reset.
`define TDH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

// ----- rtl/tdh_pkg.sv -----
// Package with shared types and constants of the timer deadline heap.
`timescale 1ns / 1ps
package tdh_pkg;
   localparam int CapacityDefault     = 64;
   localparam int DeadlineBitsDefault = 64;
   localparam int IdBits              = 6;
   localparam int TimerCount          = 64;

   typedef enum logic [1:0] {
      KIND_PUSH = 2'd0, KIND_POP = 2'd1, KIND_REMOVE = 2'd2, KIND_PEEK = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0, STATUS_INVALID = 2'd1, STATUS_FULL = 2'd2, STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_MOVE, ST_RD_PARENT, ST_UP_CMP, ST_RD_KIDS, ST_DN_CMP,
      ST_SWAP, ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch request, read root/last/slot
      logic decide;      // latch status and the moving entry
      logic do_move;     // apply push/pop/remove bookkeeping
      logic rd_parent;   // read parent of cursor
      logic up_cmp;      // latch parent as swap target
      logic rd_kids;     // read children of cursor
      logic dn_cmp;      // latch best child as swap target
      logic do_swap;     // exchange cursor with chosen slot
      logic load_out;    // load response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       finish;     // rejected request or peek: no heap change
      logic       no_work;    // no sift needed after the move
      logic       start_up;   // moved entry sifts up first
      logic       at_root;
      logic       parent_gt;  // parent strictly larger than cursor
      logic       kid_less;   // some child strictly smaller than cursor
   } stat_type;
endpackage

// ----- rtl/tdh_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module tdh_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   output logic [Width-1:0]         rd_data_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_b
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule

// ----- rtl/tdh_ctrl.sv -----
// Controller state machine sequencing each heap request.
`timescale 1ns / 1ps
module tdh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              rsp_free,
   input  tdh_pkg::stat_type stat,
   output tdh_pkg::cmd_type  cmd,
   output logic              busy
);
   import tdh_pkg::*;

   state_type state_ff, state_in;
   logic      up_ff, up_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         up_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         up_ff    <= up_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      up_in    = up_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.finish) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            cmd.do_move = 1'b1;
            up_in       = stat.start_up;
            if (stat.no_work) begin
               state_in = ST_RESP;
            end else if (stat.start_up) begin
               state_in = ST_RD_PARENT;
            end else begin
               state_in = ST_RD_KIDS;
            end
         end
         ST_RD_PARENT: begin
            cmd.rd_parent = 1'b1;
            state_in      = stat.at_root ? ST_RESP : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            cmd.up_cmp = 1'b1;
            state_in   = stat.parent_gt ? ST_SWAP : ST_RESP;
         end
         ST_RD_KIDS: begin
            cmd.rd_kids = 1'b1;
            state_in    = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            cmd.dn_cmp = 1'b1;
            state_in   = stat.kid_less ? ST_SWAP : ST_RESP;
         end
         ST_SWAP: begin
            cmd.do_swap = 1'b1;
            state_in    = up_ff ? ST_RD_PARENT : ST_RD_KIDS;
         end
         ST_RESP: begin
            if (rsp_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ----- rtl/tdh_dp.sv -----
// Datapath: heap memories, slot table, active bits and compare logic.
`timescale 1ns / 1ps
module tdh_dp #(
   parameter int Capacity     = tdh_pkg::CapacityDefault,
   parameter int DeadlineBits = tdh_pkg::DeadlineBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tdh_pkg::cmd_type            cmd,
   output tdh_pkg::stat_type           stat,
   input  logic [1:0]                  in_kind,
   input  logic [tdh_pkg::IdBits-1:0]  in_id,
   input  logic [63:0]                 in_deadline,
   output logic [1:0]                  out_status,
   output logic [tdh_pkg::IdBits-1:0]  out_id,
   output logic [63:0]                 out_deadline,
   output logic [6:0]                  out_count
);
   import tdh_pkg::*;

   localparam int AW = $clog2(Capacity);
   localparam int CW = $clog2(Capacity + 1);
   localparam int EW = DeadlineBits + IdBits;
   localparam int XW = AW + 2;

   logic [CW-1:0]           count_ff;
   logic [TimerCount-1:0]   active_ff;
   kind_type                kind_ff;
   logic [IdBits-1:0]       id_ff;
   logic [DeadlineBits-1:0] dl_ff;
   status_type              status_ff;
   logic [IdBits-1:0]       oid_ff;
   logic [DeadlineBits-1:0] odl_ff;
   logic [AW-1:0]           cur_ff;     // slot of the moving entry
   logic [EW-1:0]           cur_ent_ff; // its contents
   logic [AW-1:0]           tgt_ff;     // parent or best child
   logic [EW-1:0]           tgt_ent_ff;
   logic                    l_ok_ff, r_ok_ff;
   // second half of a swap, written while the next level is read
   logic                    pend_ff;
   logic [AW-1:0]           pend_addr_ff;
   logic [EW-1:0]           pend_ent_ff;

   // heap memory: read port a = root / parent / left, b = last / right
   logic          h_we;
   logic [AW-1:0] h_wa, h_ra, h_rb;
   logic [EW-1:0] h_wd, h_qa, h_qb;
   tdh_ram #(.Width(EW), .Depth(Capacity)) u_heap (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr_a(h_ra), .rd_data_a(h_qa), .rd_addr_b(h_rb), .rd_data_b(h_qb));

   // slot-of-timer table, read only at capture
   logic              s_we;
   logic [IdBits-1:0] s_wa;
   logic [AW-1:0]     s_wd, s_q, s_qunused;
   tdh_ram #(.Width(AW), .Depth(TimerCount)) u_slot (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr_a(in_id), .rd_data_a(s_q), .rd_addr_b(in_id), .rd_data_b(s_qunused));

   logic [CW-1:0]           last_idx;
   logic [AW-1:0]           up_idx;
   logic [XW-1:0]           l_idx, r_idx, cnt_x;
   logic                    is_push, is_pop, is_rem, is_peek, empty;
   status_type              status_in;
   logic [DeadlineBits-1:0] cur_dl, qa_dl, qb_dl;
   logic [IdBits-1:0]       cur_own;
   logic                    l_less, r_less;

   assign is_push  = (kind_ff == KIND_PUSH);
   assign is_pop   = (kind_ff == KIND_POP);
   assign is_rem   = (kind_ff == KIND_REMOVE);
   assign is_peek  = (kind_ff == KIND_PEEK);
   assign empty    = (count_ff == '0);
   assign last_idx = count_ff - CW'(1);

   assign cur_dl  = cur_ent_ff[EW-1:IdBits];
   assign cur_own = cur_ent_ff[IdBits-1:0];
   assign qa_dl   = h_qa[EW-1:IdBits];
   assign qb_dl   = h_qb[EW-1:IdBits];
   assign up_idx  = (cur_ff - AW'(1)) >> 1;
   assign l_idx   = {1'b0, cur_ff, 1'b1};
   assign r_idx   = l_idx + XW'(1);
   assign cnt_x   = XW'(count_ff);
   // left child wins a tie between children
   assign l_less  = l_ok_ff && (qa_dl < cur_dl);
   assign r_less  = r_ok_ff && (qb_dl < (l_less ? qa_dl : cur_dl));

   // request checks, valid in the decide cycle
   always_comb begin
      status_in = STATUS_OK;
      unique case (kind_ff) inside
         KIND_PUSH: begin
            if (active_ff[id_ff]) begin
               status_in = STATUS_INVALID;
            end else if (count_ff >= CW'(Capacity)) begin
               status_in = STATUS_FULL;
            end
         end
         KIND_POP, KIND_PEEK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end
         end
         KIND_REMOVE: begin
            if (!active_ff[id_ff] || (CW'(s_q) >= count_ff)) begin
               status_in = STATUS_INVALID;
            end
         end
         default: status_in = STATUS_OK;
      endcase
   end

   always_comb begin
      stat.finish    = (status_in != STATUS_OK) || is_peek;
      // count_ff is still the old count in the move cycle
      stat.no_work   = is_pop ? (count_ff == CW'(1))
                              : (is_rem && (CW'(cur_ff) == last_idx));
      stat.start_up  = is_push || (is_rem && (cur_ff != '0) && (cur_dl < qa_dl));
      stat.at_root   = (cur_ff == '0);
      stat.parent_gt = (qa_dl > cur_dl);
      stat.kid_less  = l_less || r_less;
   end

   // read addressing: root and last at capture, parent of the removed slot
   // in the decide cycle, then the sift path
   always_comb begin
      h_ra = '0;
      h_rb = last_idx[AW-1:0];
      if (cmd.decide) begin
         h_ra = (s_q - AW'(1)) >> 1;
      end
      if (cmd.rd_parent) begin
         h_ra = up_idx;
      end
      if (cmd.rd_kids) begin
         h_ra = l_idx[AW-1:0];
         h_rb = r_idx[AW-1:0];
      end
   end

   always_comb begin
      h_we = 1'b0; h_wa = cur_ff; h_wd = cur_ent_ff;
      s_we = 1'b0; s_wa = cur_own; s_wd = cur_ff;
      if (cmd.do_move) begin
         h_we = 1'b1;
         s_we = 1'b1;
      end
      if (cmd.do_swap) begin
         // cursor entry goes to target
         h_we = 1'b1; h_wa = tgt_ff;
         s_we = 1'b1; s_wd = tgt_ff;
      end
      if (pend_ff) begin
         // target entry goes to the old cursor slot
         h_we = 1'b1; h_wa = pend_addr_ff; h_wd = pend_ent_ff;
         s_we = 1'b1; s_wa = pend_ent_ff[IdBits-1:0]; s_wd = pend_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         active_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         pend_ff <= cmd.do_swap;
         if (cmd.do_move) begin
            if (is_push) begin
               count_ff         <= count_ff + CW'(1);
               active_ff[id_ff] <= 1'b1;
            end else begin
               count_ff          <= count_ff - CW'(1);
               active_ff[oid_ff] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_type'(in_kind);
         id_ff   <= in_id;
         dl_ff   <= in_deadline[DeadlineBits-1:0];
      end
      if (cmd.decide) begin
         status_ff  <= status_in;
         oid_ff     <= ((is_pop || is_peek) && !empty) ? h_qa[IdBits-1:0] : id_ff;
         odl_ff     <= ((is_pop || is_peek) && !empty) ? qa_dl : '0;
         cur_ent_ff <= is_push ? {dl_ff, id_ff} : h_qb;
         cur_ff     <= is_push ? count_ff[AW-1:0] : (is_pop ? '0 : s_q);
      end
      if (cmd.rd_kids) begin
         l_ok_ff <= (l_idx < cnt_x);
         r_ok_ff <= (r_idx < cnt_x);
      end
      if (cmd.up_cmp) begin
         tgt_ff     <= up_idx;
         tgt_ent_ff <= h_qa;
      end
      if (cmd.dn_cmp) begin
         tgt_ff     <= r_less ? r_idx[AW-1:0] : l_idx[AW-1:0];
         tgt_ent_ff <= r_less ? h_qb : h_qa;
      end
      if (cmd.do_swap) begin
         pend_addr_ff <= cur_ff;
         pend_ent_ff  <= tgt_ent_ff;
         cur_ff       <= tgt_ff;
      end
   end

   // response values
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status   <= status_ff;
         out_id       <= oid_ff;
         out_deadline <= 64'(odl_ff);
         out_count    <= 7'(count_ff);
      end
   end
endmodule

// ----- rtl/timer_deadline_min_heap.sv -----
// Top level of the timer deadline min-heap: handshakes, controller, datapath.
`timescale 1ns / 1ps
// Sequence: capture, decide, then the response for a peek or rejected request;
// else a move, then the response if a pop or remove needs no sift, else per level
// a parent read, compare and swap up, or a children read, compare and swap down.
// Throughput: one request at a time; the next is taken the cycle after the
// response register loads, so a held response stalls only the next request.
// Reset: synchronous, active high; empties the heap and clears all active bits.
module timer_deadline_min_heap #(
   parameter int CAPACITY      = tdh_pkg::CapacityDefault,
   parameter int DEADLINE_BITS = tdh_pkg::DeadlineBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [71:0] req_tdata,   // timer_id [5:0], deadline [69:6], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // status [1:0], out_timer_id [7:2],
                                    // out_deadline [71:8], count [78:72], zero fill
);
   import tdh_pkg::*;
`include "timer_deadline_min_heap_defines.svh"

   cmd_type  cmd;
   stat_type stat;
   logic     busy;
   logic     req_fire;
   logic     rsp_valid_ff;
   logic [1:0]  o_status;
   logic [5:0]  o_id;
   logic [63:0] o_dl;
   logic [6:0]  o_count;

   // accept a new request only when idle; response register parts the sides
   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;

   tdh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .rsp_free(!rsp_valid_ff || rsp_tready), .stat(stat), .cmd(cmd), .busy(busy));

   tdh_dp #(.Capacity(CAPACITY), .DeadlineBits(DEADLINE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_kind(req_tuser), .in_id(req_tdata[5:0]), .in_deadline(req_tdata[69:6]),
      .out_status(o_status), .out_id(o_id), .out_deadline(o_dl), .out_count(o_count));

   // hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, o_count, o_dl, o_id, o_status};

   `TDH_ASSERT_IMPLY(a_no_accept_busy, clock, reset, busy, !req_tready)
   `TDH_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_out, rsp_tvalid)
   `TDH_ASSERT_IMPLY(a_one_cmd, clock, reset, cmd.do_swap, !cmd.do_move && !cmd.load_out)
endmodule

// ----- dv/tb_top.sv -----
// Testbench for the timer deadline min-heap: scoreboard class and stimulus top.
`timescale 1ns / 1ps
module tb_top;
   import tdh_pkg::*;

   // Scoreboard: mirror of the indexed heap plus a queue of expected responses.
   class heap_scoreboard;
      logic [63:0] dl_of_slot [64];
      logic [5:0]  owner_of_slot [64];
      int          slot_of [64];
      bit          active [64];
      int          n_live;
      logic [79:0] expected_rsp [$];
      int          n_mismatch;
      int          n_checked;

      function void swap_slots(int a, int b);
         logic [63:0] d;
         logic [5:0]  o;
         d = dl_of_slot[a];
         o = owner_of_slot[a];
         dl_of_slot[a] = dl_of_slot[b];
         owner_of_slot[a] = owner_of_slot[b];
         dl_of_slot[b] = d;
         owner_of_slot[b] = o;
         slot_of[owner_of_slot[a]] = a;
         slot_of[owner_of_slot[b]] = b;
      endfunction

      function void sift_up(int at);
         int up;
         while (at != 0) begin
            up = (at - 1) / 2;
            if (dl_of_slot[up] <= dl_of_slot[at]) break;
            swap_slots(up, at);
            at = up;
         end
      endfunction

      function void sift_down(int at);
         int l, r, best;
         forever begin
            l = 2 * at + 1;
            r = l + 1;
            best = at;
            if (l < n_live && dl_of_slot[l] < dl_of_slot[best]) best = l;
            if (r < n_live && dl_of_slot[r] < dl_of_slot[best]) best = r;
            if (best == at) return;
            swap_slots(at, best);
            at = best;
         end
      endfunction

      // Apply one accepted request and queue the response it must produce.
      function void note_request(kind_type kind, logic [5:0] id, logic [63:0] dl);
         status_type  st;
         logic [5:0]  oid;
         logic [63:0] odl;
         int          at;
         st = STATUS_OK;
         oid = id;
         odl = '0;
         case (kind)
            KIND_PUSH: begin
               if (active[id]) st = STATUS_INVALID;
               else if (n_live >= 64) st = STATUS_FULL;
               else begin
                  at = n_live;
                  active[id] = 1;
                  dl_of_slot[at] = dl;
                  owner_of_slot[at] = id;
                  slot_of[id] = at;
                  n_live++;
                  sift_up(at);
               end
            end
            KIND_POP, KIND_PEEK: begin
               if (n_live == 0) st = STATUS_EMPTY;
               else begin
                  oid = owner_of_slot[0];
                  odl = dl_of_slot[0];
                  if (kind == KIND_POP) begin
                     active[oid] = 0;
                     n_live--;
                     if (n_live != 0) begin
                        dl_of_slot[0] = dl_of_slot[n_live];
                        owner_of_slot[0] = owner_of_slot[n_live];
                        slot_of[owner_of_slot[0]] = 0;
                        sift_down(0);
                     end
                  end
               end
            end
            default: begin
               at = slot_of[id];
               if (!active[id] || at >= n_live) st = STATUS_INVALID;
               else begin
                  active[id] = 0;
                  n_live--;
                  if (at != n_live) begin
                     dl_of_slot[at] = dl_of_slot[n_live];
                     owner_of_slot[at] = owner_of_slot[n_live];
                     slot_of[owner_of_slot[at]] = at;
                     if (at != 0 && dl_of_slot[at] < dl_of_slot[(at - 1) / 2]) sift_up(at);
                     else sift_down(at);
                  end
               end
            end
         endcase
         expected_rsp.push_back({1'b0, 7'(n_live), odl, oid, st});
      endfunction

      // Compare one response, field by field, with the oldest expectation.
      function void check_response(logic [79:0] got);
         logic [79:0] exp_rsp;
         n_checked++;
         if (expected_rsp.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected response %h", got);
            return;
         end
         exp_rsp = expected_rsp.pop_front();
         if (got[1:0] !== exp_rsp[1:0] || got[7:2] !== exp_rsp[7:2] ||
             got[71:8] !== exp_rsp[71:8] || got[78:72] !== exp_rsp[78:72]) begin
            n_mismatch++;
            if (n_mismatch <= 10)
               $display("response %0d: status %0d/%0d id %0d/%0d dl %h/%h count %0d/%0d",
                        n_checked, exp_rsp[1:0], got[1:0], exp_rsp[7:2], got[7:2],
                        exp_rsp[71:8], got[71:8], exp_rsp[78:72], got[78:72]);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;

   heap_scoreboard board = new();
   int  idle_cycles;
   int  n_requests;
   bit  sender_done;
   bit  no_stall_window;

   timer_deadline_min_heap uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Send one request: idle for the drawn gap, hold valid until the handshake,
   // then note it. Valid stays high when the next request follows at once.
   task automatic send_request(kind_type kind, logic [5:0] id, logic [63:0] dl);
      int gap;
      gap = no_stall_window ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {2'b00, dl, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, id, dl);
      n_requests++;
   endtask

   // Drop valid before waiting on the responses.
   task automatic hold_off_requests();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   // Pick a timer that is active (or any, when none is).
   function automatic logic [5:0] live_timer();
      if (board.n_live == 0) return 6'($urandom_range(0, 63));
      return board.owner_of_slot[$urandom_range(0, board.n_live - 1)];
   endfunction

   // Deadline with clustered values so that ties happen often.
   function automatic logic [63:0] pick_deadline();
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 7));
         1: return {$urandom, $urandom};
         2: return 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
         default: return 64'($urandom_range(0, 1000));
      endcase
   endfunction

   // Response side: random stall per response, sampled at the rising edge.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = no_stall_window ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_response(rsp_tdata);
      end
   end

   // Watchdog: end the run if no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("watchdog expired");
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int r;
      logic [5:0] id;
      idle_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty pops and peeks, bad removes, extreme deadlines, ties.
      send_request(KIND_POP, 6'd63, '0);
      send_request(KIND_PEEK, 6'd0, '0);
      send_request(KIND_REMOVE, 6'd5, '0);
      send_request(KIND_PUSH, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(KIND_PUSH, 6'd63, 64'd0);
      send_request(KIND_PUSH, 6'd63, 64'd7);
      send_request(KIND_PUSH, 6'd21, 64'd0);
      send_request(KIND_PUSH, 6'd42, 64'hAAAA_5555_AAAA_5555);
      send_request(KIND_PEEK, 6'd9, '0);
      send_request(KIND_REMOVE, 6'd63, '0);
      send_request(KIND_REMOVE, 6'd63, '0);
      send_request(KIND_POP, 6'd0, '0);
      send_request(KIND_POP, 6'd0, '0);
      send_request(KIND_POP, 6'd0, '0);
      send_request(KIND_POP, 6'd0, '0);
      // Fill to capacity, then push once more into the full heap.
      for (int i = 0; i < 64; i++) send_request(KIND_PUSH, 6'(i), pick_deadline());
      send_request(KIND_PUSH, 6'd17, 64'd1);
      for (int i = 0; i < 64; i++) begin
         if (board.active[i]) begin
            board.active[i] = board.active[i];
         end
      end
      // Pressure: drain everything before the random part.
      hold_off_requests();
      while (board.expected_rsp.size() != 0) @(posedge clock);

      // Random: weighted towards pushes while small, pops and removes while large.
      for (int n = 0; n < 470; n++) begin
         no_stall_window = (n >= 200 && n < 260);
         r = $urandom_range(0, 99);
         if (r < 45 - (board.n_live > 48 ? 25 : 0))
            send_request(KIND_PUSH, 6'($urandom_range(0, 63)), pick_deadline());
         else if (r < 70) send_request(KIND_POP, 6'($urandom_range(0, 63)), '0);
         else if (r < 88) begin
            id = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : live_timer();
            send_request(KIND_REMOVE, id, '0);
         end else send_request(KIND_PEEK, 6'($urandom_range(0, 63)), '0);
         if (n == 400) begin
            hold_off_requests();
            while (board.expected_rsp.size() != 0) @(posedge clock);
            repeat (30) @(posedge clock);
         end
      end
      no_stall_window = 0;
      hold_off_requests();

      r = 0;
      while (board.expected_rsp.size() != 0 && r < 5000) begin
         @(posedge clock);
         r++;
      end
      repeat (40) @(posedge clock);
      $display("sent %0d requests of all four kinds, including full, empty and tie cases",
               n_requests);
      $display("checked %0d responses, %0d mismatching", board.n_checked, board.n_mismatch);
      if (board.n_mismatch == 0 && board.expected_rsp.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tdh_pkg.sv
rtl/tdh_ram.sv
rtl/tdh_ctrl.sv
rtl/tdh_dp.sv
rtl/timer_deadline_min_heap.sv
dv/tb_top.sv
